// File: rtl/thac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thac_pkg: shared types and constants of the TCP/IP header anomaly checker
// Holds the anomaly bit positions, header word positions, the per-word
// check result bundle and the TCP flag combination check.
// ----------------------------------------------------------------------------
package thac_pkg;

   // Widths of the datapath.
   localparam int WordW  = 16;
   localparam int FlagW  = 18;
   localparam int IdxW   = 6;
   localparam int TotalW = 5;
   localparam int ExpW   = 17;

   typedef logic [WordW-1:0]  word_type;
   typedef logic [FlagW-1:0]  flags_type;
   typedef logic [IdxW-1:0]   index_type;
   typedef logic [TotalW-1:0] total_type;
   typedef logic [ExpW-1:0]   expect_type;

   // Anomaly bit positions in the result mask.
   localparam int FlSynFin    = 0;
   localparam int FlSynRst    = 1;
   localparam int FlFinRst    = 2;
   localparam int FlFinNoAck  = 3;
   localparam int FlPshNoAck  = 4;
   localparam int FlUrgNoAck  = 5;
   localparam int FlNoFlags   = 6;
   localparam int FlFinOnly   = 7;
   localparam int FlFinPsh    = 8;
   localparam int FlDoffShort = 9;
   localparam int FlVersion   = 10;
   localparam int FlTtlZero   = 11;
   localparam int FlIhlShort  = 12;
   localparam int FlProtocol  = 13;
   localparam int FlTos       = 14;
   localparam int FlLength    = 15;
   localparam int FlChecksum  = 16;
   localparam int FlDfFrag    = 17;

   // Word positions within the IP header.
   localparam index_type IdxVerIhl   = 6'd0;
   localparam index_type IdxLength   = 6'd1;
   localparam index_type IdxFrag     = 6'd3;
   localparam index_type IdxTtlProto = 6'd4;
   localparam index_type IdxSumLast  = 6'd9;
   localparam index_type SumWords    = 6'd10;

   // Offsets from the end of the IP part to the TCP flag word and last word.
   localparam index_type TcpFlagOfs = 6'd6;
   localparam index_type TcpLastOfs = 6'd9;

   localparam total_type  DefaultTotal = 5'd10;
   localparam word_type   ChecksumOk   = 16'hFFFF;
   localparam expect_type FixedTcpLen  = 17'd20;

   localparam logic [3:0] MinIhl     = 4'd5;
   localparam logic [3:0] MinDoff    = 4'd5;
   localparam logic [3:0] Version4   = 4'd4;
   localparam logic [3:0] Version6   = 4'd6;
   localparam logic [7:0] MaxTos     = 8'd6;
   localparam logic [7:0] ProtoTcp   = 8'd6;

   // Next state and new anomaly bits for one header word.
   typedef struct packed {
      word_type  sum_next;
      total_type total_next;
      word_type  length_next;
      flags_type new_flags;
      logic      last;
   } word_result_type;

   // Bad TCP flag combinations and short data offset, from the flags word.
   function automatic flags_type tcp_flag_checks(input word_type w);
      logic fin;
      logic syn;
      logic rst;
      logic psh;
      logic ack;
      logic urg;
      logic quiet;
      flags_type f;
      fin   = w[0];
      syn   = w[1];
      rst   = w[2];
      psh   = w[3];
      ack   = w[4];
      urg   = w[5];
      quiet = !urg && !ack && !rst && !syn;
      f = '0;
      f[FlSynFin]    = syn && fin;
      f[FlSynRst]    = syn && rst;
      f[FlFinRst]    = fin && rst;
      f[FlFinNoAck]  = !ack && fin;
      f[FlPshNoAck]  = !ack && psh;
      f[FlUrgNoAck]  = !ack && urg;
      f[FlNoFlags]   = quiet && !psh && !fin;
      f[FlFinOnly]   = quiet && !psh && fin;
      f[FlFinPsh]    = quiet && psh && fin;
      f[FlDoffShort] = w[15:12] < MinDoff;
      return f;
   endfunction

endpackage

// File: rtl/thac_word_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thac_word_check: checks of one header word
// Given the word, its position and the header state, works out the running
// checksum, captured fields, new anomaly bits and whether the word is last.
// ----------------------------------------------------------------------------
module thac_word_check (
   input  thac_pkg::word_type        header_word,
   input  thac_pkg::word_type        payload_bytes,
   input  thac_pkg::index_type       word_index,
   input  thac_pkg::word_type        checksum_sum,
   input  thac_pkg::total_type       ip_word_total,
   input  thac_pkg::word_type        length_field,
   output thac_pkg::word_result_type result
);
   import thac_pkg::*;

   logic [WordW:0] raw_sum;
   word_type       folded_sum;
   logic [3:0]     ihl;
   index_type      flag_pos;
   index_type      last_pos;
   expect_type     expect_len;

   // Ones-complement add with end-around carry.
   assign raw_sum    = {1'b0, checksum_sum} + {1'b0, header_word};
   assign folded_sum = raw_sum[WordW-1:0] + {{(WordW-1){1'b0}}, raw_sum[WordW]};
   assign ihl        = header_word[11:8];

   // Positions of the TCP flags word and the final TCP word.
   assign flag_pos = {1'b0, ip_word_total} + TcpFlagOfs;
   assign last_pos = {1'b0, ip_word_total} + TcpLastOfs;

   // Expected total length, kept one bit wider so overflow never matches.
   assign expect_len = {{(ExpW-TotalW-1){1'b0}}, ip_word_total, 1'b0} + FixedTcpLen
                       + {1'b0, payload_bytes};

   always_comb begin
      result             = '0;
      result.sum_next    = (word_index < SumWords) ? folded_sum : checksum_sum;
      result.total_next  = ip_word_total;
      result.length_next = length_field;
      result.last        = (word_index == last_pos);

      // Field checks of the IP header words.
      if (word_index == IdxVerIhl) begin
         result.new_flags[FlVersion]  = (header_word[15:12] != Version4) &&
                                        (header_word[15:12] != Version6);
         result.new_flags[FlIhlShort] = ihl < MinIhl;
         result.new_flags[FlTos]      = header_word[7:0] > MaxTos;
         result.total_next            = (ihl > MinIhl) ? {ihl, 1'b0} : DefaultTotal;
      end else if (word_index == IdxLength) begin
         result.length_next = header_word;
      end else if (word_index == IdxFrag) begin
         result.new_flags[FlDfFrag] = header_word[14] && (header_word[12:0] != 13'd0);
      end else if (word_index == IdxTtlProto) begin
         result.new_flags[FlTtlZero]  = header_word[15:8] == 8'd0;
         result.new_flags[FlProtocol] = header_word[7:0] != ProtoTcp;
      end

      // Checksum verdict once the tenth word has been added.
      if (word_index == IdxSumLast) begin
         result.new_flags[FlChecksum] = folded_sum != ChecksumOk;
      end

      // TCP flag combinations.
      if (word_index == flag_pos) begin
         result.new_flags = result.new_flags | tcp_flag_checks(header_word);
      end

      // Length comparison on the final word.
      if (result.last) begin
         result.new_flags[FlLength] = {1'b0, length_field} != expect_len;
      end
   end

endmodule

// File: rtl/tcp_ip_header_anomaly_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_ip_header_anomaly_checker_core: IPv4/TCP header sanity checker
// Walks a header one 16-bit word per transfer and reports an anomaly mask.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries header words in network order, the IP header
//   first (10 words, or ihl*2 words when ihl exceeds 5) and then 10 TCP
//   words. req_payload_bytes is only looked at with the final TCP word.
//   Every word other than the final TCP word is absorbed with no output.
//   After the final TCP word, one transfer on the rsp_ channel carries the
//   18-bit anomaly mask and the packet_bad summary bit.
//   Throughput is one word per cycle but for the stall below: each word
//   is checked by a small add and compare and folded into the header state
//   in the cycle it transfers. The result appears in the rsp_ register in
//   the cycle after the final word. When the receiver stalls, the result
//   is held in that register and new words are still taken until another
//   final word arrives, which waits until the held result transfers.
//   Reset returns the block to the start of a header with no result pending.
// ----------------------------------------------------------------------------
module tcp_ip_header_anomaly_checker_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  thac_pkg::word_type     req_header_word,
   input  thac_pkg::word_type     req_payload_bytes,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output thac_pkg::flags_type    rsp_error_flags,
   output logic                   rsp_packet_bad
);
   import thac_pkg::*;

   index_type       word_index_ff,    word_index_in;
   word_type        checksum_sum_ff,  checksum_sum_in;
   total_type       ip_word_total_ff, ip_word_total_in;
   word_type        length_field_ff,  length_field_in;
   flags_type       partial_flags_ff, partial_flags_in;
   logic            rsp_valid_ff,     rsp_valid_in;
   flags_type       rsp_flags_ff,     rsp_flags_in;
   logic            rsp_bad_ff,       rsp_bad_in;
   word_result_type check;
   logic            accept;
   logic            finish;
   flags_type       final_flags;

   // Per-word checks.
   thac_word_check u_word_check (
      .header_word   (req_header_word),
      .payload_bytes (req_payload_bytes),
      .word_index    (word_index_ff),
      .checksum_sum  (checksum_sum_ff),
      .ip_word_total (ip_word_total_ff),
      .length_field  (length_field_ff),
      .result        (check)
   );

   // A word transfers unless a held result would be overwritten.
   assign req_ready   = !rsp_valid_ff || rsp_ready || !check.last;
   assign accept      = req_valid && req_ready;
   assign finish      = accept && check.last;
   assign final_flags = partial_flags_ff | check.new_flags;

   // Header state: advance on every word, restart after the final word.
   always_comb begin
      word_index_in    = word_index_ff;
      checksum_sum_in  = checksum_sum_ff;
      ip_word_total_in = ip_word_total_ff;
      length_field_in  = length_field_ff;
      partial_flags_in = partial_flags_ff;
      if (finish) begin
         word_index_in    = '0;
         checksum_sum_in  = '0;
         ip_word_total_in = DefaultTotal;
         length_field_in  = '0;
         partial_flags_in = '0;
      end else if (accept) begin
         word_index_in    = word_index_ff + 6'd1;
         checksum_sum_in  = check.sum_next;
         ip_word_total_in = check.total_next;
         length_field_in  = check.length_next;
         partial_flags_in = final_flags;
      end
   end

   // Result register: loaded on the final word, cleared when taken.
   always_comb begin
      rsp_flags_in = rsp_flags_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_flags_in = final_flags;
         rsp_bad_in   = final_flags != '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_index_ff    <= '0;
         checksum_sum_ff  <= '0;
         ip_word_total_ff <= DefaultTotal;
         length_field_ff  <= '0;
         partial_flags_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         word_index_ff    <= word_index_in;
         checksum_sum_ff  <= checksum_sum_in;
         ip_word_total_ff <= ip_word_total_in;
         length_field_ff  <= length_field_in;
         partial_flags_ff <= partial_flags_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_flags_ff <= rsp_flags_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_error_flags = rsp_flags_ff;
   assign rsp_packet_bad  = rsp_bad_ff;

endmodule
